// ===== hw/rtl/fkg_pkg.sv =====
// ---------------------------------------------------------------------------
// fkg_pkg
// shared types and constants for the fractional knapsack block
// ---------------------------------------------------------------------------
`default_nettype none
package fkg_pkg;
	localparam int MAX_ITEMS = 32;
	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int CAP_W = 22;
	localparam int FRAC_W = 17;
	localparam int TOT_W = 37;
	localparam int SUM_W = 38;
	localparam int DIV_W = 38;

	typedef struct packed {
		logic [15:0] profit;
		logic [15:0] weight;
		logic        last_item;
	} req_t;

	typedef struct packed {
		logic [4:0]        rank;
		logic [15:0]       item_profit;
		logic [15:0]       item_weight;
		logic [FRAC_W-1:0] fraction;
		logic [TOT_W-1:0]  total_profit;
		logic              last_result;
	} res_t;

	typedef enum logic [2:0] {
		ST_LOAD, ST_INIT, ST_FILL, ST_DIV, ST_MUL, ST_ACC, ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // insert request into the sorted cells
		logic init;     // load capacity, clear sum, rank
		logic fill;     // evaluate item at rank
		logic div_start;
		logic mul;
		logic acc;
		logic emit;
		logic clear;    // end of run
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fits;
		logic partial_done;
		logic div_done;
		logic rank_end;   // current rank is last
	} sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/fkg_ctrl.sv =====
// ---------------------------------------------------------------------------
// fkg_ctrl
// sequencer for load, greedy fill and result emission
// ---------------------------------------------------------------------------
`default_nettype none
module fkg_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          last_item,
	input  wire fkg_pkg::sts_t sts,
	output fkg_pkg::cmd_t      cmd,
	output logic               busy
);
	import fkg_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_LOAD);
		unique case (state_q)
			ST_LOAD: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_item) state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d = ST_FILL;
			end
			ST_FILL: begin
				if (sts.partial_done || sts.fits) begin
					cmd.fill = 1'b1;
					state_d = ST_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: if (sts.div_done) state_d = ST_MUL;
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.rank_end) begin
					cmd.clear = 1'b1;
					state_d = ST_LOAD;
				end else state_d = ST_FILL;
			end
			default: state_d = ST_LOAD;
		endcase
	end
endmodule
`default_nettype wire

// ===== hw/rtl/fkg_div.sv =====
// ---------------------------------------------------------------------------
// fkg_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none
module fkg_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [21:0] dividend, // remaining capacity, shifted by 16 inside
	input  wire logic [15:0] divisor,
	output logic [16:0]      quot,
	output logic             done
);
	import fkg_pkg::*;

	logic [DIV_W-1:0] num_q;
	logic [16:0]      rem_q;
	logic [5:0]       cnt_q;
	logic             run_q;
	logic [16:0]      trial;
	logic [17:0]      diff;

	assign trial = {rem_q[15:0], num_q[DIV_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= 6'(DIV_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= {dividend, 16'h0000};
			rem_q <= '0;
		end else if (run_q) begin
			// quotient bits shift into the low end of num_q
			if (!diff[17]) rem_q <= diff[16:0];
			else rem_q <= trial;
			num_q <= {num_q[DIV_W-2:0], ~diff[17]};
		end
	end

	// quotient is below 65536 since remaining < divisor
	assign quot = num_q[16:0];
	assign done = !run_q && !go;
endmodule
`default_nettype wire

// ===== hw/rtl/fkg_dp.sv =====
// ---------------------------------------------------------------------------
// fkg_dp
// insertion sorting cells, greedy fill datapath and result register
// ---------------------------------------------------------------------------
`default_nettype none
module fkg_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fkg_pkg::cmd_t       cmd,
	input  wire fkg_pkg::req_t       req,
	input  wire logic [21:0]         cap,
	output fkg_pkg::sts_t            sts,
	output fkg_pkg::res_t            res,
	output logic                     res_valid
);
	import fkg_pkg::*;

	logic [15:0]      cp_q [MAX_ITEMS];
	logic [15:0]      cw_q [MAX_ITEMS];
	logic [CNT_W-1:0] cnt_q;
	logic             above [MAX_ITEMS];
	logic [IDX_W-1:0] rank_q;
	logic [CAP_W-1:0] rem_q;
	logic [SUM_W-1:0] sum_q;
	logic             pdone_q;
	logic [16:0]      frac_q;
	logic [32:0]      prod_q;
	logic [15:0]      cur_p, cur_w;
	logic [16:0]      quot;
	logic             div_done;

	// newcomer goes ahead of cell k when its ratio is strictly higher
	always_comb begin
		for (int k = 0; k < MAX_ITEMS; k++)
			above[k] = (32'(req.profit) * 32'(cw_q[k])) > (32'(cp_q[k]) * 32'(req.weight));
	end

	always_ff @(posedge clk) begin
		if (cmd.load && cnt_q != CNT_W'(MAX_ITEMS)) begin
			for (int k = 0; k < MAX_ITEMS; k++) begin
				if (CNT_W'(k) < cnt_q) begin
					if (above[k]) begin
						if (k > 0) begin
							cp_q[k] <= (CNT_W'(k-1) < cnt_q && !above[k-1]) ? req.profit : cp_q[k-1];
							cw_q[k] <= (CNT_W'(k-1) < cnt_q && !above[k-1]) ? req.weight : cw_q[k-1];
						end else begin
							cp_q[k] <= req.profit;
							cw_q[k] <= req.weight;
						end
					end
				end else if (CNT_W'(k) == cnt_q) begin
					if (k > 0 && above[k-1]) begin
						cp_q[k] <= cp_q[k-1];
						cw_q[k] <= cw_q[k-1];
					end else begin
						cp_q[k] <= req.profit;
						cw_q[k] <= req.weight;
					end
				end
			end
		end
	end

	assign cur_p = cp_q[rank_q];
	assign cur_w = cw_q[rank_q];

	fkg_div u_div (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_start),
		.dividend(rem_q), .divisor(cur_w), .quot(quot), .done(div_done)
	);

	logic is_last;
	assign is_last = ({1'b0, rank_q} == CNT_W'(cnt_q - 1'b1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rank_q <= '0;
			rem_q <= '0;
			sum_q <= '0;
			pdone_q <= 1'b0;
			frac_q <= '0;
			prod_q <= '0;
			res <= '0;
			res_valid <= 1'b0;
		end else begin
			res_valid <= cmd.emit;
			if (cmd.load && cnt_q != CNT_W'(MAX_ITEMS)) cnt_q <= cnt_q + 1'b1;
			if (cmd.init) begin
				rem_q <= cap;
				sum_q <= '0;
				rank_q <= '0;
				pdone_q <= 1'b0;
			end
			if (cmd.fill) begin
				if (pdone_q) frac_q <= '0;
				else begin
					frac_q <= 17'h10000;
					sum_q <= sum_q + {6'd0, cur_p, 16'h0000};
					rem_q <= rem_q - CAP_W'(cur_w);
				end
			end
			if (cmd.mul) begin
				frac_q <= quot;
				prod_q <= 33'(cur_p) * 33'(quot);
			end
			if (cmd.acc) begin
				sum_q <= sum_q + SUM_W'(prod_q);
				rem_q <= '0;
				pdone_q <= 1'b1;
			end
			if (cmd.emit) begin
				res.rank <= 5'(rank_q);
				res.item_profit <= cur_p;
				res.item_weight <= cur_w;
				res.fraction <= frac_q;
				res.total_profit <= is_last ? sum_q[TOT_W-1:0] : '0;
				res.last_result <= is_last;
				rank_q <= rank_q + 1'b1;
			end
			if (cmd.clear) cnt_q <= '0;
		end
	end

	assign sts.fits = ({6'd0, cur_w} <= rem_q);
	assign sts.partial_done = pdone_q;
	assign sts.div_done = div_done;
	assign sts.rank_end = is_last;
endmodule
`default_nettype wire

// ===== hw/rtl/fractional_knapsack_greedy_top.sv =====
// ---------------------------------------------------------------------------
// fractional_knapsack_greedy_top
// greedy fractional knapsack over ratio-sorted items
// ---------------------------------------------------------------------------
// loading: one request per cycle, each inserted into the sorting cells at once
// solve: a setup state, then fill and emit per whole or skipped item, and fill,
// bit-serial divide, multiply, accumulate and emit for the one divided item; each
// result strobe comes in the cycle after its emit cycle
// results cannot be stalled; busy is high from the cycle after the last
// request and drops in the cycle the final result is strobed
// reset clears the controller, item count, sums and result register; cells
// hold no reset
`default_nettype none
module fractional_knapsack_greedy_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire fkg_pkg::req_t request,
	output fkg_pkg::res_t      result,
	output logic               result_valid,
	input  wire logic          cfg_we,
	input  wire logic [21:0]   cfg_wdata
);
	import fkg_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [CAP_W-1:0] capacity_q;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) capacity_q <= '0;
		else if (cfg_we) capacity_q <= cfg_wdata;
	end

	fkg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .last_item(request.last_item),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	fkg_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req(request), .cap(capacity_q),
		.sts(sts), .res(result), .res_valid(result_valid)
	);

	// no request taken while results are going out
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.load) else $error("load while busy");
	// result strobe follows an emit command
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(cmd.emit)) else $error("stray result");
	// final result ends the run
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_result) |-> !busy) else $error("busy after last");
endmodule
`default_nettype wire

// ===== dv/fractional_knapsack_greedy_checker.sv =====
// ---------------------------------------------------------------------------
// fractional_knapsack_greedy_checker
// watches the request and result channels, predicts the ranked fill of each
// set from its own model of the block and compares every result field by field
// ---------------------------------------------------------------------------
`default_nettype none
module fractional_knapsack_greedy_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           busy,
	input  wire fkg_pkg::req_t  request,
	input  wire fkg_pkg::res_t  result,
	input  wire logic           result_valid,
	input  wire logic           cfg_we,
	input  wire logic [21:0]    cfg_wdata,
	output int                  fail_count,
	output int                  pending
);
	import fkg_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic [15:0]      set_profit[$];
	logic [15:0]      set_weight[$];
	res_t             ranked_q[$];

	assign pending = ranked_q.size();

	// rank the set, fill greedily and queue the expected results
	task automatic solve_set();
		logic [15:0] op[$];
		logic [15:0] ow[$];
		logic [16:0] frac[$];
		logic [63:0] room;
		logic [63:0] acc;
		bit          cut;
		int          j;
		int          n;
		res_t        r;
		n = set_profit.size();
		for (int i = 0; i < n; i++) begin
			j = op.size();
			while (j > 0 && 64'(set_profit[i]) * ow[j-1] > 64'(op[j-1]) * set_weight[i])
				j--;
			op.insert(j, set_profit[i]);
			ow.insert(j, set_weight[i]);
		end
		room = cap_q;
		acc = 0;
		cut = 0;
		for (int i = 0; i < n; i++) begin
			if (cut) begin
				frac.push_back(17'd0);
			end else if (ow[i] <= room) begin
				frac.push_back(17'h10000);
				acc += 64'(op[i]) << 16;
				room -= ow[i];
			end else begin
				frac.push_back(17'((room << 16) / ow[i]));
				acc += 64'(op[i]) * frac[i];
				room = 0;
				cut = 1;
			end
		end
		for (int i = 0; i < n; i++) begin
			r.rank = 5'(i);
			r.item_profit = op[i];
			r.item_weight = ow[i];
			r.fraction = frac[i];
			r.last_result = (i == n - 1);
			r.total_profit = r.last_result ? TOT_W'(acc) : '0;
			ranked_q.push_back(r);
		end
		set_profit.delete();
		set_weight.delete();
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			cap_q <= '0;
			fail_count <= 0;
			ranked_q.delete();
			set_profit.delete();
			set_weight.delete();
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (result_valid) begin
				if (ranked_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result %p", result);
				end else begin
					want = ranked_q.pop_front();
					if (result !== want) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected %p actual %p", want, result);
					end
				end
			end
			if (start && !busy) begin
				if (set_profit.size() < MAX_ITEMS) begin
					set_profit.push_back(request.profit);
					set_weight.push_back(request.weight);
				end
				if (request.last_item) solve_set();
			end
		end
	end
endmodule
`default_nettype wire

// ===== dv/fractional_knapsack_greedy_top_tb.sv =====
// ---------------------------------------------------------------------------
// fractional_knapsack_greedy_top_tb
// drives item sets of random size and content through the knapsack block
// under several capacities; the checker predicts and compares each result
// ---------------------------------------------------------------------------
`default_nettype none
module fractional_knapsack_greedy_top_tb;
	import fkg_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        request;
	res_t        result;
	logic        result_valid;
	logic        cfg_we;
	logic [21:0] cfg_wdata;
	int          fail_count;
	int          pending;
	int          cycle_count = 0;

	fractional_knapsack_greedy_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .result(result), .result_valid(result_valid),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	fractional_knapsack_greedy_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .result(result), .result_valid(result_valid),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog: worst case is well under this even with 32-item sets
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 600000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// idle cycles between requests: mostly short, now and then long
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// send one request and hold it until the block takes it; start stays
	// high so the next request can follow back to back
	task automatic send_request(input logic [15:0] p, input logic [15:0] w, input logic l);
		start <= 1'b1;
		request <= '{profit: p, weight: w, last_item: l};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// wait for every queued result, then let the block settle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [21:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random payload with mixed ranges so every bit toggles
	function automatic logic [15:0] pick16(input bit nonzero);
		logic [15:0] v;
		case ($urandom_range(0, 3))
			0: v = 16'($urandom_range(0, 15));
			1: v = 16'hffff - 16'($urandom_range(0, 15));
			default: v = 16'($urandom);
		endcase
		if (nonzero && v == 0) v = 1;
		return v;
	endfunction

	task automatic random_set(input int size);
		for (int i = 0; i < size; i++) begin
			idle_gap();
			send_request(pick16(1'b0), pick16(1'b1), i == size - 1);
		end
	endtask

	initial begin
		int sent;
		int size;
		logic [21:0] caps[5];
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero capacity, a lone item, extremes
		send_request(16'hffff, 16'hffff, 1'b1);
		drain();
		write_capacity(22'h3fffff);
		// everything fits
		send_request(16'd0, 16'd1, 1'b0);
		send_request(16'hffff, 16'd1, 1'b0);
		send_request(16'd5, 16'hffff, 1'b0);
		send_request(16'd5, 16'hffff, 1'b1);
		drain();
		write_capacity(22'd100);
		// ties in ratio keep arrival order, partial item in the middle
		send_request(16'd10, 16'd20, 1'b0);
		send_request(16'd20, 16'd40, 1'b0);
		send_request(16'd300, 16'd70, 1'b0);
		send_request(16'd7, 16'd3, 1'b0);
		send_request(16'd1, 16'd200, 1'b1);
		drain();
		// overfull store: 36 items, the extras ignored, last mark still solves
		write_capacity(22'd50000);
		for (int i = 0; i < 36; i++)
			send_request(pick16(1'b0), pick16(1'b1), i == 35);
		drain();

		// random sets under several capacities, extremes included
		caps = '{22'd0, 22'd1, 22'd3000, 22'd200000, 22'h3fffff};
		sent = 0;
		while (sent < 330) begin
			if ($urandom_range(0, 5) == 0) begin
				drain();
				write_capacity(($urandom_range(0, 1) == 0) ? caps[$urandom_range(0, 4)]
					: 22'($urandom));
			end
			size = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 6);
			random_set(size);
			sent += size;
			// now and then, pause until the set has fully drained
			if ($urandom_range(0, 7) == 0) drain();
		end
		drain();

		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

// ===== fractional_knapsack_greedy_top.f =====
hw/rtl/fkg_pkg.sv
hw/rtl/fkg_ctrl.sv
hw/rtl/fkg_div.sv
hw/rtl/fkg_dp.sv
hw/rtl/fractional_knapsack_greedy_top.sv
dv/fractional_knapsack_greedy_checker.sv
dv/fractional_knapsack_greedy_top_tb.sv
